>>> rtl/upbt_pkg.sv
package upbt_pkg;

   localparam logic [1:0] CMD_BIND   = 2'd0;
   localparam logic [1:0] CMD_UNBIND = 2'd1;
   localparam logic [1:0] CMD_ALLOC  = 2'd2;
   localparam logic [1:0] CMD_LOOKUP = 2'd3;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_FULL      = 3'd1;
   localparam logic [2:0] STATUS_BOUND     = 3'd2;
   localparam logic [2:0] STATUS_MALFORMED = 3'd3;
   localparam logic [2:0] STATUS_NOLISTEN  = 3'd4;
   localparam logic [2:0] STATUS_EXHAUSTED = 3'd5;

   localparam logic [15:0] EPHEMERAL_RESET = 16'd49152;
   localparam int          TRIES_W         = 15;
   localparam logic [14:0] ALLOC_TRIES     = 15'd16384;
   localparam logic [15:0] UDP_HDR_BYTES   = 16'd8;

   typedef enum logic [1:0] {
      S_IDLE,
      S_START,
      S_SCAN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [15:0] port;
      logic [15:0] handle;
      logic        rcv;
   } entry_type;

   typedef struct packed {
      logic load_req;
      logic start_try;
      logic start_scan;
      logic finish;
   } ctrl_type;

   typedef struct packed {
      logic malformed;
      logic is_alloc;
      logic scan_done;
      logic hit;
      logic tries_max;
      logic out_free;
   } stat_type;

endpackage

>>> rtl/upbt_ctrl.sv
module upbt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  upbt_pkg::stat_type stat,
   output upbt_pkg::ctrl_type ctrl
);

   upbt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= upbt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         upbt_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.load_req = 1'b1;
               state_in      = upbt_pkg::S_START;
            end
         end
         upbt_pkg::S_START: begin
            if (stat.malformed) begin
               state_in = upbt_pkg::S_FINISH;
            end else begin
               // each allocation try takes a fresh candidate port
               ctrl.start_try  = stat.is_alloc;
               ctrl.start_scan = 1'b1;
               state_in        = upbt_pkg::S_SCAN;
            end
         end
         upbt_pkg::S_SCAN: begin
            if (stat.scan_done) begin
               if (stat.is_alloc && stat.hit && !stat.tries_max) begin
                  state_in = upbt_pkg::S_START;
               end else begin
                  state_in = upbt_pkg::S_FINISH;
               end
            end
         end
         upbt_pkg::S_FINISH: begin
            if (stat.out_free) begin
               ctrl.finish = 1'b1;
               state_in    = upbt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = upbt_pkg::S_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/upbt_dp.sv
module upbt_dp #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  upbt_pkg::ctrl_type ctrl,
   output upbt_pkg::stat_type stat,
   input  logic [1:0]         req_cmd,
   input  logic [15:0]        req_port,
   input  logic [15:0]        req_handle,
   input  logic               req_has_receiver,
   input  logic [15:0]        req_src_port,
   input  logic [15:0]        req_udp_length,
   input  logic [15:0]        req_ip_payload_length,
   input  logic [31:0]        req_src_ip,
   input  logic               csr_write_enable,
   input  logic [15:0]        csr_write_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [3:0]         rsp_slot,
   output logic [15:0]        rsp_receiver_handle,
   output logic [15:0]        rsp_port_out,
   output logic [15:0]        rsp_src_port_out,
   output logic [31:0]        rsp_src_ip_out,
   output logic [15:0]        rsp_payload_length
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int TRIES_W_L = upbt_pkg::TRIES_W;

   // captured transaction
   logic [1:0]  cmd_ff;
   logic [15:0] port_ff;
   logic [15:0] handle_ff;
   logic        rcv_ff;
   logic [15:0] sport_ff;
   logic [15:0] ulen_ff;
   logic [15:0] iplen_ff;
   logic [31:0] sip_ff;

   logic [15:0] base_ff;

   // table storage
   upbt_pkg::entry_type       mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0]  used_ff, used_in;

   // scan pipeline
   logic                scan_active_ff;
   logic [CNT_W-1:0]    rd_idx_ff;
   logic [IDX_W-1:0]    raddr;
   logic                cmp_valid_ff;
   logic [IDX_W-1:0]    cmp_idx_ff;
   logic                rd_used_ff;
   upbt_pkg::entry_type rd_entry_ff;
   logic                issue;

   logic                hit_ff;
   logic [IDX_W-1:0]    match_idx_ff;
   logic [15:0]         match_handle_ff;
   logic                free_found_ff;
   logic [IDX_W-1:0]    free_idx_ff;

   // allocation
   logic [15:0]         cand_ff;
   logic [15:0]         next_eph_ff, next_eph_in;
   logic [15:0]         eph_inc;
   logic [TRIES_W_L-1:0] tries_ff;

   logic [15:0] key;
   logic        entry_match;
   logic        cur_hit;
   logic        stop;
   logic        last;
   logic        scan_done;
   logic        malformed;
   logic        bind_we;
   logic        out_free;

   // result registers
   logic        rsp_valid_ff;
   logic [2:0]  status_ff, status_in;
   logic [3:0]  slot_ff, slot_in;
   logic [15:0] rhandle_ff, rhandle_in;
   logic [15:0] port_out_ff, port_out_in;
   logic [15:0] sport_out_ff, sport_out_in;
   logic [31:0] sip_out_ff, sip_out_in;
   logic [15:0] plen_ff, plen_in;

   assign malformed = (cmd_ff == upbt_pkg::CMD_LOOKUP) &&
                      ((iplen_ff < upbt_pkg::UDP_HDR_BYTES) ||
                       (ulen_ff < upbt_pkg::UDP_HDR_BYTES) ||
                       (ulen_ff > iplen_ff));

   assign key         = (cmd_ff == upbt_pkg::CMD_ALLOC) ? cand_ff : port_ff;
   assign entry_match = cmp_valid_ff && rd_used_ff && (rd_entry_ff.port == key);
   assign cur_hit     = entry_match && ((cmd_ff != upbt_pkg::CMD_LOOKUP) || rd_entry_ff.rcv);
   // unbind walks the whole table, the others stop at the first hit
   assign stop        = cur_hit && (cmd_ff != upbt_pkg::CMD_UNBIND);
   assign last        = (cmp_idx_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign scan_done   = cmp_valid_ff && (stop || last);
   assign issue       = scan_active_ff && !scan_done &&
                        (rd_idx_ff != CNT_W'(TABLE_ENTRIES));
   assign raddr       = rd_idx_ff[IDX_W-1:0];

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign bind_we  = ctrl.finish && (cmd_ff == upbt_pkg::CMD_BIND) &&
                     !hit_ff && free_found_ff;

   assign eph_inc     = next_eph_ff + 16'd1;
   assign next_eph_in = (eph_inc == 16'd0) ? base_ff : eph_inc;

   always_comb begin
      stat.malformed = malformed;
      stat.is_alloc  = (cmd_ff == upbt_pkg::CMD_ALLOC);
      stat.scan_done = scan_done;
      stat.hit       = cur_hit;
      stat.tries_max = (tries_ff == upbt_pkg::ALLOC_TRIES);
      stat.out_free  = out_free;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_req) begin
         cmd_ff    <= req_cmd;
         port_ff   <= req_port;
         handle_ff <= req_handle;
         rcv_ff    <= req_has_receiver;
         sport_ff  <= req_src_port;
         ulen_ff   <= req_udp_length;
         iplen_ff  <= req_ip_payload_length;
         sip_ff    <= req_src_ip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= upbt_pkg::EPHEMERAL_RESET;
      end else if (csr_write_enable) begin
         base_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (bind_we) begin
         mem[free_idx_ff] <= '{port: port_ff, handle: handle_ff, rcv: rcv_ff};
      end
      rd_entry_ff <= mem[raddr];
   end

   always_comb begin
      used_in = used_ff;
      if (cmp_valid_ff && (cmd_ff == upbt_pkg::CMD_UNBIND) && entry_match) begin
         used_in[cmp_idx_ff] = 1'b0;
      end
      if (bind_we) begin
         used_in[free_idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_active_ff <= 1'b0;
         cmp_valid_ff   <= 1'b0;
         rd_idx_ff      <= '0;
      end else if (ctrl.start_scan) begin
         scan_active_ff <= 1'b1;
         cmp_valid_ff   <= 1'b0;
         rd_idx_ff      <= '0;
      end else begin
         if (scan_done) begin
            scan_active_ff <= 1'b0;
         end
         cmp_valid_ff <= issue;
         if (issue) begin
            rd_idx_ff <= rd_idx_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         cmp_idx_ff <= raddr;
         rd_used_ff <= used_ff[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (ctrl.start_scan) begin
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmp_valid_ff) begin
         if (cur_hit && !hit_ff) begin
            hit_ff <= 1'b1;
         end
         if (!rd_used_ff && !free_found_ff) begin
            free_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_valid_ff && cur_hit && !hit_ff) begin
         match_idx_ff    <= cmp_idx_ff;
         match_handle_ff <= rd_entry_ff.handle;
      end
      if (cmp_valid_ff && !rd_used_ff && !free_found_ff) begin
         free_idx_ff <= cmp_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_eph_ff <= upbt_pkg::EPHEMERAL_RESET;
         tries_ff    <= '0;
      end else if (ctrl.load_req) begin
         tries_ff <= '0;
      end else if (ctrl.start_try) begin
         next_eph_ff <= next_eph_in;
         tries_ff    <= tries_ff + TRIES_W_L'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start_try) begin
         cand_ff <= next_eph_ff;
      end
   end

   always_comb begin
      status_in    = upbt_pkg::STATUS_OK;
      slot_in      = 4'd0;
      rhandle_in   = 16'd0;
      port_out_in  = port_ff;
      sport_out_in = 16'd0;
      sip_out_in   = 32'd0;
      plen_in      = 16'd0;
      unique case (cmd_ff)
         upbt_pkg::CMD_BIND: begin
            if (hit_ff) begin
               status_in = upbt_pkg::STATUS_BOUND;
            end else if (free_found_ff) begin
               slot_in = 4'(free_idx_ff);
            end else begin
               status_in = upbt_pkg::STATUS_FULL;
            end
         end
         upbt_pkg::CMD_UNBIND: begin
            status_in = upbt_pkg::STATUS_OK;
         end
         upbt_pkg::CMD_ALLOC: begin
            // a hit on the final try means every try was taken
            if (hit_ff) begin
               status_in   = upbt_pkg::STATUS_EXHAUSTED;
               port_out_in = 16'd0;
            end else begin
               port_out_in = cand_ff;
            end
         end
         upbt_pkg::CMD_LOOKUP: begin
            if (malformed) begin
               status_in = upbt_pkg::STATUS_MALFORMED;
            end else if (hit_ff) begin
               slot_in      = 4'(match_idx_ff);
               rhandle_in   = match_handle_ff;
               sport_out_in = sport_ff;
               sip_out_in   = sip_ff;
               plen_in      = ulen_ff - upbt_pkg::UDP_HDR_BYTES;
            end else begin
               status_in = upbt_pkg::STATUS_NOLISTEN;
            end
         end
         default: begin
            status_in = upbt_pkg::STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         status_ff    <= status_in;
         slot_ff      <= slot_in;
         rhandle_ff   <= rhandle_in;
         port_out_ff  <= port_out_in;
         sport_out_ff <= sport_out_in;
         sip_out_ff   <= sip_out_in;
         plen_ff      <= plen_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_slot            = slot_ff;
   assign rsp_receiver_handle = rhandle_ff;
   assign rsp_port_out        = port_out_ff;
   assign rsp_src_port_out    = sport_out_ff;
   assign rsp_src_ip_out      = sip_out_ff;
   assign rsp_payload_length  = plen_ff;

   a_bind_free_slot: assert property (@(posedge clock) disable iff (reset)
      bind_we |-> !used_ff[free_idx_ff])
      else $error("bind writes an occupied slot");

   a_unbind_clears: assert property (@(posedge clock) disable iff (reset)
      (cmp_valid_ff && (cmd_ff == upbt_pkg::CMD_UNBIND) && entry_match)
      |=> !used_ff[$past(cmp_idx_ff)])
      else $error("unbind left a matching slot in use");

   a_tries_bound: assert property (@(posedge clock) disable iff (reset)
      tries_ff <= upbt_pkg::ALLOC_TRIES)
      else $error("allocation tried too many ports");

   a_finish_room: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |-> out_free)
      else $error("result overwrites an untaken transaction");

endmodule

>>> rtl/udp_port_binding_table.sv
// udp port binding table
// req_ channel: one transaction per command (bind, unbind, allocate, lookup)
// with all header fields; accepted when req_valid and req_ready are high.
// rsp_ channel: exactly one result transaction per command, held in an
// output register until rsp_ready; the block goes back to accepting the next
// request while that result waits, and only stalls a later finish on it.
// csr_ port: ephemeral_base, written when csr_write_enable is high; write it
// only while no command is in flight.
// the table is walked one slot per cycle from a single read port;
// rsp_valid and req_ready rise together once a result is registered.
// a lookup or bind that hits slot k stops early; a malformed lookup
// skips the walk and goes straight to its result.
// allocate walks the table once per candidate port, up to 16384 candidates.
// reset: all slots free, ephemeral_base and the port counter at 49152,
// no result pending.
module udp_port_binding_table #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_port,
   input  logic [15:0] req_handle,
   input  logic        req_has_receiver,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_udp_length,
   input  logic [15:0] req_ip_payload_length,
   input  logic [31:0] req_src_ip,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_slot,
   output logic [15:0] rsp_receiver_handle,
   output logic [15:0] rsp_port_out,
   output logic [15:0] rsp_src_port_out,
   output logic [31:0] rsp_src_ip_out,
   output logic [15:0] rsp_payload_length
);

   upbt_pkg::ctrl_type ctrl;
   upbt_pkg::stat_type stat;

   upbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   upbt_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .ctrl                  (ctrl),
      .stat                  (stat),
      .req_cmd               (req_cmd),
      .req_port              (req_port),
      .req_handle            (req_handle),
      .req_has_receiver      (req_has_receiver),
      .req_src_port          (req_src_port),
      .req_udp_length        (req_udp_length),
      .req_ip_payload_length (req_ip_payload_length),
      .req_src_ip            (req_src_ip),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_slot              (rsp_slot),
      .rsp_receiver_handle   (rsp_receiver_handle),
      .rsp_port_out          (rsp_port_out),
      .rsp_src_port_out      (rsp_src_port_out),
      .rsp_src_ip_out        (rsp_src_ip_out),
      .rsp_payload_length    (rsp_payload_length)
   );

endmodule
